@@ src/ccp_pkg.sv @@
// Shared types, constants and the CRC step function of the codeword packer.
`timescale 1ns / 1ps
`default_nettype none

package ccp_pkg;

    localparam int MAX_GEN_BITS = 9;
    localparam int MIN_GEN_BITS = 2;
    localparam int BYTE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int REM_W        = MAX_GEN_BITS - 1;
    localparam int STREAM_W     = 2 * (NIB_W + REM_W);
    localparam int WORD_W       = 32;
    localparam int SHIFT_W      = WORD_W + BYTE_W;

    localparam logic [8:0] GEN_BITS_RESET  = 9'd11;
    localparam logic [3:0] GEN_LEN_RESET   = 4'd4;
    localparam logic       WORD_MODE_RESET = 1'b1;

    typedef enum logic [1:0] {
        REG_GEN_BITS  = 2'd0,
        REG_GEN_LEN   = 2'd1,
        REG_WORD_MODE = 2'd2
    } cfg_reg_t;

    // Settings derived from the configuration registers
    typedef struct packed {
        logic       word_mode;
        logic [3:0] rbits;     // remainder length, 1..8
        logic [7:0] poly_la;   // generator low bits, left-aligned in 8 bits
        logic [2:0] nbytes;    // codeword bytes per input byte, 2..4
        logic [3:0] pad;       // leading zero bits, 1..8
    } cfg_t;

    // One input byte after CRC, ready for the byte serializer
    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic                first;
        logic [2:0]          nbytes;
        logic [3:0]          pad;
    } item_t;

    // Four bits of modulo-2 division; remainder kept left-aligned in 8 bits
    function automatic logic [7:0] crc_nibble(input logic [7:0] r_in,
                                              input logic [3:0] bits,
                                              input logic [7:0] poly_la);
        logic [7:0] r;
        logic       fb;
        r = r_in;
        for (int i = NIB_W - 1; i >= 0; i--) begin
            fb = bits[i] ^ r[7];
            r  = {r[6:0], 1'b0} ^ (fb ? poly_la : 8'h00);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/crc_codeword_packer.sv @@
// Top level of the CRC codeword packer.
//
//  channel   signals                               direction
//  config    cfg_we, cfg_index, cfg_data           in, write only
//  input     in_valid, in_stall, data_byte, first  in (stall out)
//  output    out_valid, out_stall, out_byte, last  out (stall in)
//
// Three register stages take one byte per cycle unless stalled; the first output
// byte shows once the serializer loads it from stage 3. The serializer sets the
// rate: an input byte gives 2 to 4 output bytes, plus a header byte if first.
// Reset loads generator_bits 11, generator_length 4 and the 8-bit word mode.
// Output stall backs up through the stages; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module crc_codeword_packer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [8:0]    cfg_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          first_of_stream,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               last
);
    import ccp_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    ccp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccp_crc_pipe u_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .first_of_stream (first_of_stream),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take)
    );

    ccp_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule

`default_nettype wire

@@ src/ccp_cfg_regs.sv @@
// Configuration registers and the settings derived from them.
`timescale 1ns / 1ps
`default_nettype none

module ccp_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [8:0]    cfg_data,
    output ccp_pkg::cfg_t      cfg
);
    import ccp_pkg::*;

    // Bit 8 of the generator is the implied leading one, so it is not stored
    logic [7:0] gen_bits_reg;
    logic [3:0] gen_len_reg;
    logic       word_mode_reg;
    logic [3:0] len_clamped;
    logic [3:0] rbits;
    logic [4:0] total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_bits_reg  <= GEN_BITS_RESET[7:0];
            gen_len_reg   <= GEN_LEN_RESET;
            word_mode_reg <= WORD_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GEN_BITS:  gen_bits_reg  <= cfg_data[7:0];
                REG_GEN_LEN:   gen_len_reg   <= cfg_data[3:0];
                REG_WORD_MODE: word_mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        priority if (gen_len_reg < 4'(MIN_GEN_BITS))
            len_clamped = 4'(MIN_GEN_BITS);
        else if (gen_len_reg > 4'(MAX_GEN_BITS))
            len_clamped = 4'(MAX_GEN_BITS);
        else
            len_clamped = gen_len_reg;

        rbits = len_clamped - 4'd1;
        total = word_mode_reg ? 5'(5'd8 + 5'(rbits)) : 5'(5'd8 + 5'({rbits, 1'b0}));

        cfg.word_mode = word_mode_reg;
        cfg.rbits     = rbits;
        // Bits at or above the remainder length shift out of the top
        cfg.poly_la   = 8'(gen_bits_reg << (4'd8 - rbits));
        cfg.nbytes    = 3'(total[4:3]) + 3'd1;
        cfg.pad       = 4'd8 - 4'(total[2:0]);
    end

endmodule

`default_nettype wire

@@ src/ccp_crc_pipe.sv @@
// Three-stage CRC pipeline: remainders, then codeword stream assembly.
`timescale 1ns / 1ps
`default_nettype none

module ccp_crc_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ccp_pkg::cfg_t      cfg,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          first_of_stream,
    output logic               item_valid,
    output ccp_pkg::item_t     item,
    input  wire logic          item_take
);
    import ccp_pkg::*;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic       s1_ready, s2_ready, s3_ready;

    logic [7:0] s1_data_reg;
    logic       s1_first_reg;
    logic [7:0] s1_ra_reg;
    logic [7:0] s1_rb_reg;

    logic [7:0] s2_data_reg;
    logic       s2_first_reg;
    logic [7:0] s2_rem_hi_reg;
    logic [7:0] s2_rem_lo_reg;

    item_t      s3_item_reg;

    logic [7:0] ra_next, rb_next;
    logic [7:0] r_hi_full;
    logic [7:0] rem_hi_next, rem_lo_next;
    logic [4:0] cwbits;
    logic [11:0] c1, c2;
    logic [STREAM_W-1:0] stream_next;

    assign s3_ready = !s3_valid_reg || item_take;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // Stage 1: high nibble, and low nibble for the two-word mode
    assign ra_next = crc_nibble(8'h00, data_byte[7:4], cfg.poly_la);
    assign rb_next = crc_nibble(8'h00, data_byte[3:0], cfg.poly_la);

    // Stage 2: finish the 8-bit word, right-align the remainders
    assign r_hi_full   = cfg.word_mode ? crc_nibble(s1_ra_reg, s1_data_reg[3:0], cfg.poly_la)
                                       : s1_ra_reg;
    assign rem_hi_next = 8'(r_hi_full >> (4'd8 - cfg.rbits));
    assign rem_lo_next = 8'(s1_rb_reg >> (4'd8 - cfg.rbits));

    // Stage 3: dataword followed by remainder; in two-word mode, two codewords back to back
    always_comb
    begin
        cwbits = 5'(5'd4 + 5'(cfg.rbits));
        c1 = 12'({8'h00, s2_data_reg[7:4]} << cfg.rbits) | 12'(s2_rem_hi_reg);
        c2 = 12'({8'h00, s2_data_reg[3:0]} << cfg.rbits) | 12'(s2_rem_lo_reg);
        if (cfg.word_mode)
            stream_next = STREAM_W'({16'h0000, s2_data_reg} << cfg.rbits)
                        | STREAM_W'(s2_rem_hi_reg);
        else
            stream_next = STREAM_W'({12'h000, c1} << cwbits) | STREAM_W'(c2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_of_stream;
            s1_ra_reg    <= ra_next;
            s1_rb_reg    <= rb_next;
        end
        if (s2_ready)
        begin
            s2_data_reg   <= s1_data_reg;
            s2_first_reg  <= s1_first_reg;
            s2_rem_hi_reg <= rem_hi_next;
            s2_rem_lo_reg <= rem_lo_next;
        end
        if (s3_ready)
        begin
            s3_item_reg.stream <= stream_next;
            s3_item_reg.first  <= s2_first_reg;
            s3_item_reg.nbytes <= cfg.nbytes;
            s3_item_reg.pad    <= cfg.pad;
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

endmodule

`default_nettype wire

@@ src/ccp_serializer.sv @@
// Byte serializer: header byte on a first item, then codeword bytes MSB first.
`timescale 1ns / 1ps
`default_nettype none

module ccp_serializer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  ccp_pkg::item_t     item,
    output logic               item_take,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               last
);
    import ccp_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;
    logic [2:0]         count_reg;
    logic               xfer;
    logic               load_ok;
    logic [WORD_W-1:0]  aligned;
    logic [4:0]         align_sh;

    assign out_valid = (count_reg != 3'd0);
    assign out_byte  = shift_reg[SHIFT_W-1 -: BYTE_W];
    assign last      = (count_reg == 3'd1);
    assign xfer      = out_valid && !out_stall;

    // Take the next item as the final byte of the current one goes out
    assign load_ok   = !out_valid || (last && !out_stall);
    assign item_take = item_valid && load_ok;

    // Drop unused leading bytes so the padded stream starts at the top
    assign align_sh = {2'(3'd4 - item.nbytes), 3'b000};
    assign aligned  = WORD_W'({8'h00, item.stream} << align_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else if (item_take)
            count_reg <= item.nbytes + 3'(item.first);
        else if (xfer)
            count_reg <= count_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            if (item.first)
                shift_reg <= {4'h0, item.pad, aligned};
            else
                shift_reg <= {aligned, 8'h00};
        end
        else if (xfer)
            shift_reg <= {shift_reg[SHIFT_W-BYTE_W-1:0], 8'h00};
    end

endmodule

`default_nettype wire

@@ src/ccp_checker.sv @@
// Port-level checker for the codeword packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ccp_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       last
);
    logic       in_xfer, out_xfer, end_xfer;
    logic [2:0] byte_cnt_reg;
    logic [3:0] open_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign end_xfer = out_xfer && last;

    // Bytes sent so far for the current input byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_cnt_reg <= 3'd0;
        else if (end_xfer)
            byte_cnt_reg <= 3'd0;
        else if (out_xfer)
            byte_cnt_reg <= byte_cnt_reg + 3'd1;
    end

    // Input bytes taken whose final output byte has not gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 4'd0;
        else if (in_xfer && !end_xfer)
            open_reg <= open_reg + 4'd1;
        else if (end_xfer && !in_xfer)
            open_reg <= open_reg - 4'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output changed while stalled");

    a_min_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        end_xfer |-> byte_cnt_reg != 3'd0)
        else $error("input byte ended after a single output byte");

    a_max_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_cnt_reg == 3'd4 |-> last)
        else $error("more than five output bytes for one input byte");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 4'd0)
        else $error("output byte with no input byte outstanding");

endmodule

bind crc_codeword_packer ccp_checker u_ccp_checker (.*);

`default_nettype wire
